// ----- rtl/core/dsle_pkg.sv -----
`default_nettype none

package dsle_pkg;

  // Request codes carried in the opcode field.
  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  entry_count;
    logic [31:0] front_value;
    logic [31:0] back_value;
    logic        is_empty;
  } out_beat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_PUSH_RD,
    S_PUSH_CHK,
    S_FIND_RD,
    S_FIND_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FIN,
    S_FIN_FRONT,
    S_FIN_BACK,
    S_DONE
  } state_t;

  // Where the memory read address comes from.
  typedef enum logic [2:0] {
    RS_PTR_PREV,
    RS_PTR,
    RS_PTR_NEXT,
    RS_FRONT,
    RS_LAST
  } rd_sel_t;

  typedef struct packed {
    logic       load_req;
    logic       ptr_load_count;
    logic       ptr_clear;
    logic       ptr_dec;
    logic       ptr_inc;
    logic       rd_en;
    rd_sel_t    rd_sel;
    logic       wr_en;
    logic       wr_from_rd;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       set_status;
    logic [1:0] status_code;
    logic       cap_front;
    logic       cap_back;
    logic       clr_ends;
    logic       load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       empty;
    logic       full;
    logic       ptr_zero;
    logic       ptr_at_end;
    logic       next_at_end;
    logic       rd_le;
    logic       rd_eq;
    logic       out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/dsle_ctrl.sv -----
`default_nettype none

module dsle_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  dsle_pkg::dp_stat_t stat,
  output dsle_pkg::dp_cmd_t  cmd
);
  import dsle_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.op)
          OP_PUSH: begin
            if (stat.full) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_FULL;
              state_nxt       = S_FIN;
            end else begin
              cmd.ptr_load_count = 1'b1;
              state_nxt          = S_PUSH_RD;
            end
          end
          OP_POP: begin
            if (stat.empty) begin
              state_nxt = S_FIN;
            end else begin
              cmd.ptr_clear = 1'b1;
              state_nxt     = S_SHIFT_RD;
            end
          end
          OP_REMOVE: begin
            cmd.ptr_clear = 1'b1;
            state_nxt     = S_FIND_RD;
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_PUSH_RD: begin
        if (stat.ptr_zero) begin
          cmd.wr_en   = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RS_PTR_PREV;
          state_nxt  = S_PUSH_CHK;
        end
      end
      S_PUSH_CHK: begin
        cmd.wr_en = 1'b1;
        if (stat.rd_le) begin
          cmd.wr_from_rd = 1'b1;
          cmd.ptr_dec    = 1'b1;
          state_nxt      = S_PUSH_RD;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_FIN;
        end
      end
      S_FIND_RD: begin
        if (stat.ptr_at_end) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_NOT_FOUND;
          state_nxt       = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RS_PTR;
          state_nxt  = S_FIND_CHK;
        end
      end
      S_FIND_CHK: begin
        if (stat.rd_eq) begin
          state_nxt = S_SHIFT_RD;
        end else begin
          cmd.ptr_inc = 1'b1;
          state_nxt   = S_FIND_RD;
        end
      end
      S_SHIFT_RD: begin
        if (stat.next_at_end) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RS_PTR_NEXT;
          state_nxt  = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_en      = 1'b1;
        cmd.wr_from_rd = 1'b1;
        cmd.ptr_inc    = 1'b1;
        state_nxt      = S_SHIFT_RD;
      end
      S_FIN: begin
        if (stat.empty) begin
          cmd.clr_ends = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RS_FRONT;
          state_nxt  = S_FIN_FRONT;
        end
      end
      S_FIN_FRONT: begin
        cmd.cap_front = 1'b1;
        cmd.rd_en     = 1'b1;
        cmd.rd_sel    = RS_LAST;
        state_nxt     = S_FIN_BACK;
      end
      S_FIN_BACK: begin
        cmd.cap_back = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/dsle_dp.sv -----
`default_nettype none

module dsle_dp #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  dsle_pkg::in_beat_t  in_beat,
  output logic                out_valid,
  input  wire                 out_ready,
  output dsle_pkg::out_beat_t out_beat,
  input  dsle_pkg::dp_cmd_t   cmd,
  output dsle_pkg::dp_stat_t  stat
);
  import dsle_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [VALUE_WIDTH-1:0] mem [CAPACITY];

  logic [1:0]             op_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [1:0]             status_r;
  logic [CW-1:0]          count_r;
  logic [CW-1:0]          ptr_r;
  logic [VALUE_WIDTH-1:0] rd_r;
  logic [VALUE_WIDTH-1:0] front_r;
  logic [VALUE_WIDTH-1:0] back_r;
  logic                   out_valid_r;
  out_beat_t              out_beat_r;

  logic [CW-1:0]          ptr_prev;
  logic [CW-1:0]          ptr_next;
  logic [CW-1:0]          last_idx;
  logic [CW-1:0]          rd_idx;
  logic [VALUE_WIDTH-1:0] wr_data;

  assign ptr_prev = ptr_r - CW'(1);
  assign ptr_next = ptr_r + CW'(1);
  assign last_idx = count_r - CW'(1);
  assign wr_data  = cmd.wr_from_rd ? rd_r : val_r;

  always_comb begin
    unique case (cmd.rd_sel)
      RS_PTR_PREV: rd_idx = ptr_prev;
      RS_PTR:      rd_idx = ptr_r;
      RS_PTR_NEXT: rd_idx = ptr_next;
      RS_FRONT:    rd_idx = '0;
      RS_LAST:     rd_idx = last_idx;
      default:     rd_idx = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[ptr_r[AW-1:0]] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_r <= mem[rd_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.cnt_dec) begin
        count_r <= last_idx;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_r     <= in_beat.opcode;
      val_r    <= VALUE_WIDTH'(in_beat.value);
      status_r <= ST_OK;
    end else if (cmd.set_status) begin
      status_r <= cmd.status_code;
    end
    priority if (cmd.ptr_load_count) begin
      ptr_r <= count_r;
    end else if (cmd.ptr_clear) begin
      ptr_r <= '0;
    end else if (cmd.ptr_dec) begin
      ptr_r <= ptr_prev;
    end else if (cmd.ptr_inc) begin
      ptr_r <= ptr_next;
    end
    if (cmd.cap_front) begin
      front_r <= rd_r;
    end else if (cmd.clr_ends) begin
      front_r <= '0;
    end
    if (cmd.cap_back) begin
      back_r <= rd_r;
    end else if (cmd.clr_ends) begin
      back_r <= '0;
    end
    if (cmd.load_out) begin
      out_beat_r.status      <= status_r;
      out_beat_r.entry_count <= 5'(count_r);
      out_beat_r.front_value <= 32'(front_r);
      out_beat_r.back_value  <= 32'(back_r);
      out_beat_r.is_empty    <= (count_r == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  always_comb begin
    stat.op          = op_r;
    stat.empty       = (count_r == '0);
    stat.full        = (count_r == CW'(CAPACITY));
    stat.ptr_zero    = (ptr_r == '0);
    stat.ptr_at_end  = (ptr_r >= count_r);
    stat.next_at_end = (ptr_next >= count_r);
    stat.rd_le       = (rd_r <= val_r);
    stat.rd_eq       = (rd_r == val_r);
    stat.out_free    = !out_valid_r || out_ready;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_no_grow_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> count_r < CW'(CAPACITY))
    else $error("insert committed into a full store");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out && status_r == ST_FULL) |-> count_r == CW'(CAPACITY))
    else $error("full status reported on a store with room");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out && count_r != '0) |-> front_r >= back_r)
    else $error("front entry is smaller than back entry");

endmodule

`default_nettype wire

// ----- rtl/core/descending_sorted_list_engine.sv -----
// One request at a time. Dispatch on the opcode; an unused opcode or a full push goes straight to
//   the finish. Push moves each entry not larger than the value back one place from the end, then
//   writes it; remove scans from the front; pop and a found remove shift later entries forward.
//   The finish reads the front and back entries, or clears them when empty. The single-port memory
//   allows one access per cycle; the next beat is taken once the result is in the output register.
// Reset: synchronous active-low; clears the entry count and handshake state, not the entries.
`default_nettype none

module descending_sorted_list_engine #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  dsle_pkg::in_beat_t  in_beat,
  output logic                out_valid,
  input  wire                 out_ready,
  output dsle_pkg::out_beat_t out_beat
);
  import dsle_pkg::*;

  // The controller steps through one request at a time and drives the datapath
  // through a command struct; the datapath owns the entry memory, the count,
  // the scan pointer and the output register, and reports flags back.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer: dispatches on the opcode, walks the insertion point from the
  // back for push, scans from the front for remove, then closes the gap for
  // remove and pop. It finishes by reading the front and back entries, or clears them when the store is empty.
  dsle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: the entries live in a single-port memory with a registered
  // read. The result beat is held in its own register, so a new request can
  // be taken while the previous result still waits for the consumer.
  dsle_dp #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

`default_nettype wire

// ----- test/sorted_store_checker.sv -----
module sorted_store_checker #(
  parameter int CAPACITY = 16
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  wire                 in_ready,
  input  dsle_pkg::in_beat_t  in_beat,
  input  wire                 out_valid,
  input  wire                 out_ready,
  input  dsle_pkg::out_beat_t out_beat,
  output int                  fail_count,
  output int                  pending
);
  import dsle_pkg::*;

  // Shadow copy of the sorted store, largest value at index zero.
  logic [31:0] shadow_entries [CAPACITY];
  int          shadow_count;
  out_beat_t   predicted_results [$];
  out_beat_t   want;

  initial begin
    fail_count   = 0;
    pending      = 0;
    shadow_count = 0;
  end

  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i + 1];
    shadow_count--;
  endfunction

  function automatic out_beat_t apply_request(in_beat_t req);
    int         pos;
    logic       found;
    logic [1:0] status;
    out_beat_t  res;
    status = ST_OK;
    case (req.opcode)
      OP_PUSH: begin
        if (shadow_count >= CAPACITY) begin
          status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < shadow_count && shadow_entries[pos] > req.value) pos++;
          for (int i = shadow_count; i > pos; i--) shadow_entries[i] = shadow_entries[i - 1];
          shadow_entries[pos] = req.value;
          shadow_count++;
        end
      end
      OP_POP: begin
        if (shadow_count > 0) drop_entry(0);
      end
      OP_REMOVE: begin
        found = 1'b0;
        pos   = 0;
        while (!found && pos < shadow_count) begin
          if (shadow_entries[pos] == req.value) found = 1'b1;
          else pos++;
        end
        if (found) drop_entry(pos);
        else status = ST_NOT_FOUND;
      end
      default: ;
    endcase
    res.status      = status;
    res.entry_count = 5'(shadow_count);
    res.is_empty    = (shadow_count == 0);
    res.front_value = (shadow_count == 0) ? 32'd0 : shadow_entries[0];
    res.back_value  = (shadow_count == 0) ? 32'd0 : shadow_entries[shadow_count - 1];
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] expected_val,
                                      logic [31:0] actual_val);
    if (expected_val !== actual_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name,
               expected_val, actual_val);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_count = 0;
      predicted_results.delete();
    end else begin
      if (in_valid && in_ready) predicted_results.push_back(apply_request(in_beat));
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, expected none, actual %h",
                   $time, out_beat);
          fail_count++;
        end else begin
          want = predicted_results.pop_front();
          check_field("status", 32'(want.status), 32'(out_beat.status));
          check_field("entry_count", 32'(want.entry_count), 32'(out_beat.entry_count));
          check_field("front_value", want.front_value, out_beat.front_value);
          check_field("back_value", want.back_value, out_beat.back_value);
          check_field("is_empty", 32'(want.is_empty), 32'(out_beat.is_empty));
        end
      end
    end
    pending = predicted_results.size();
  end

endmodule

// ----- test/testbench.sv -----
module testbench;
  import dsle_pkg::*;

  // The opcode field has one code the block does not use; it must be ignored.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS   = 1250;
  // The sender stops at this random item until every result is back.
  localparam int PAUSE_AT       = 700;
  // The receiver holds off this long before taking this result beat.
  localparam int HOLD_AT        = 400;
  localparam int HOLD_CYCLES    = 300;
  // Cycles without any accepted beat before the run is declared hung. The worst
  // correct gap is the long receiver hold plus one push into a full-length store.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 60;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_mode_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_beat;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_beat;

  int fail_count;
  int pending;

  descending_sorted_list_engine dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_beat  (in_beat),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_beat (out_beat)
  );

  // The checker watches both channels on its own; this module only makes traffic.
  sorted_store_checker #(.CAPACITY(16)) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: any cycle in which neither channel moves a beat counts toward the limit.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
          $display("testbench failed");
          $finish;
        end
      end
    end
  end

  // Receiver. Before each result beat it waits a random number of cycles, except in
  // quiet stretches where it takes every beat at once. Once in the run it holds off for
  // a long time while the sender keeps offering, so the block backs up into its input.
  int   results_taken;
  int   rx_gap;
  logic rx_quiet;
  initial begin
    out_ready     = 1'b0;
    rx_quiet      = 1'b0;
    results_taken = 0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (results_taken % 50 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      if (results_taken == HOLD_AT) rx_gap = HOLD_CYCLES;
      else if (rx_quiet) rx_gap = 0;
      else rx_gap = $urandom_range(0, 8);
      if (rx_gap > 0) begin
        out_ready <= 1'b0;
        repeat (rx_gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_taken++;
      @(negedge clk);
    end
  end

  // Sender side bookkeeping, indexed by opcode.
  int   sent_by_op [4];
  logic tx_quiet;

  // Offers one request beat. It is entered and left at a falling edge. Valid drops only
  // when a gap is drawn, so back-to-back beats keep it high without a glitch.
  task automatic send_beat(input logic [1:0] op, input logic [31:0] val);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= in_beat_t'{opcode: op, value: val};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_by_op[op]++;
    @(negedge clk);
  endtask

  logic [31:0] value_pool [8];
  logic [1:0]  pick_op;
  logic [31:0] pick_val;
  mix_mode_t   mix_mode;
  int          phase_left;
  int          push_pct;
  int          pop_pct;
  int          roll;

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_beat  = '0;
    tx_quiet = 1'b0;
    for (int i = 0; i < 4; i++) sent_by_op[i] = 0;
    for (int i = 0; i < 8; i++) value_pool[i] = $urandom();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. Start with pop and remove on an empty store: pop still reports ok
    // and remove reports not found.
    send_beat(OP_POP, 32'd0);
    send_beat(OP_REMOVE, 32'd5);
    // Largest value in, a miss on a non-empty store, then pop the only entry.
    send_beat(OP_PUSH, 32'hFFFF_FFFF);
    send_beat(OP_REMOVE, 32'd0);
    send_beat(OP_POP, 32'hFFFF_FFFF);
    // Smallest value in and removed again, so removing the last entry clears both ends.
    send_beat(OP_PUSH, 32'd0);
    send_beat(OP_REMOVE, 32'd0);
    // Equal values, both extremes, and removal of the first of two equal entries.
    send_beat(OP_PUSH, 32'd7);
    send_beat(OP_PUSH, 32'd7);
    send_beat(OP_PUSH, 32'hFFFF_FFFF);
    send_beat(OP_PUSH, 32'd0);
    send_beat(OP_REMOVE, 32'd7);
    // Fill the store to capacity, then push once more to see the full status.
    send_beat(OP_PUSH, 32'hAAAA_AAAA);
    send_beat(OP_PUSH, 32'h5555_5555);
    for (int k = 0; k < 11; k++) send_beat(OP_PUSH, $urandom());
    send_beat(OP_PUSH, 32'h8000_0000);
    // The unused opcode must leave the full store alone.
    send_beat(OP_UNUSED, $urandom());

    // Random part. It runs in phases that lean toward filling, draining or a balance,
    // so the store swings between empty and full. Many values come from a small
    // pool, which makes duplicates and successful removes common.
    phase_left = 0;
    mix_mode   = MIX_FILL;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 60);
        mix_mode   = mix_mode_t'($urandom_range(0, 2));
        tx_quiet   = ($urandom_range(0, 3) == 0);
      end
      phase_left--;

      // Once in the run the sender lets the block drain completely before going on.
      if (n == PAUSE_AT) begin
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        @(negedge clk);
      end

      case (mix_mode)
        MIX_FILL: begin
          push_pct = 75;
          pop_pct  = 10;
        end
        MIX_DRAIN: begin
          push_pct = 20;
          pop_pct  = 40;
        end
        default: begin
          push_pct = 45;
          pop_pct  = 20;
        end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 3) pick_op = OP_UNUSED;
      else if (roll < 3 + push_pct) pick_op = OP_PUSH;
      else if (roll < 3 + push_pct + pop_pct) pick_op = OP_POP;
      else pick_op = OP_REMOVE;

      case ($urandom_range(0, 9))
        0:          pick_val = 32'd0;
        1:          pick_val = 32'hFFFF_FFFF;
        2, 3, 4, 5: pick_val = value_pool[$urandom_range(0, 7)];
        6:          pick_val = $urandom_range(0, 15);
        default:    pick_val = $urandom();
      endcase

      send_beat(pick_op, pick_val);
    end

    // All stimulus is in. Wait for every expected result, then give the block a
    // little longer so a stray extra beat would still be caught.
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d requests: %0d push, %0d pop, %0d remove, %0d unused opcode.",
             sent_by_op[OP_PUSH] + sent_by_op[OP_POP] + sent_by_op[OP_REMOVE]
             + sent_by_op[OP_UNUSED], sent_by_op[OP_PUSH], sent_by_op[OP_POP],
             sent_by_op[OP_REMOVE], sent_by_op[OP_UNUSED]);
    $display("Compared %0d result beats across random stalls, a long output hold and a drain.",
             results_taken);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
